// ===== rtl/swtt_pkg.sv =====
// shared constants, types and codes for the sliding window trend test
`default_nettype none
package swtt_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_W      = 6;
    localparam int LEN_W       = 7;
    localparam int CT_W        = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int MUL_W       = 120;
    localparam int MPLR_W      = 48;
    localparam int STEP_W      = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_T    = 2'd1;

    // command codes
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // trend codes
    localparam logic [1:0] TREND_UNKNOWN = 2'd0;
    localparam logic [1:0] TREND_RISING  = 2'd1;
    localparam logic [1:0] TREND_STEADY  = 2'd2;
    localparam logic [1:0] TREND_FALLING = 2'd3;

    // multiply steps of the slope test
    localparam logic [STEP_W-1:0] STEP_NSXY = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SXSY = 4'd1;
    localparam logic [STEP_W-1:0] STEP_NSXX = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SXSX = 4'd3;
    localparam logic [STEP_W-1:0] STEP_NSYY = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SYSY = 4'd5;
    localparam logic [STEP_W-1:0] STEP_AA   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_BC   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_LHS  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_CTCT = 4'd9;
    localparam logic [STEP_W-1:0] STEP_RHS  = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MGO,
        ST_MWAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [MUL_W-1:0]  mcand;
        logic [MPLR_W-1:0] mplr;
    } mul_req_t;

endpackage
`default_nettype wire

// ===== rtl/swtt_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none
module swtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/swtt_mul.sv =====
// shared shift-and-add multiplier, one multiplier bit per cycle
`default_nettype none
module swtt_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire swtt_pkg::mul_req_t req,
    output logic                   done,
    output logic [swtt_pkg::MUL_W-1:0] product
);
    import swtt_pkg::*;

    logic              busy_reg, busy_next;
    logic [MUL_W-1:0]  acc_reg, acc_next;
    logic [MUL_W-1:0]  mcand_reg, mcand_next;
    logic [MPLR_W-1:0] mplr_reg, mplr_next;

    assign done    = busy_reg && (mplr_reg == '0);
    assign product = acc_reg;

    // one add and shift per cycle until the multiplier runs out of ones
    always_comb
    begin
        busy_next  = busy_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            acc_next   = '0;
            mcand_next = req.mcand;
            mplr_next  = req.mplr;
        end
        else if (busy_reg)
        begin
            if (mplr_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                acc_next   = acc_reg + (mplr_reg[0] ? mcand_reg : '0);
                mcand_next = {mcand_reg[MUL_W-2:0], 1'b0};
                mplr_next  = {1'b0, mplr_reg[MPLR_W-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
    end

endmodule
`default_nettype wire

// ===== rtl/sliding_window_trend_test_top.sv =====
// sliding window least-squares slope trend test, top level
//
//  channel | signals                          | direction
//  in      | in_valid in_ready command sample | request in
//  out     | out_valid out_ready trend_code   | request out
//  cfg     | cfg_write_en cfg_index cfg_data  | write only
//
// a clear request empties the window and gives no result; a push while the window fills
// gives the unknown code; a full-window push walks the window, runs the eleven steps
// of the slope test in the shared shift-and-add unit, each until its multiplier operand
// has no ones left, and then hands the result over
// reset empties the window and restores the register defaults
// a result waiting on out_ready holds the next result in the block, and no further
// request is taken until that next result is handed over
`default_nettype none
module sliding_window_trend_test_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  command,
    input  wire logic signed [swtt_pkg::SAMPLE_BITS-1:0] sample_value,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [1:0]                                 trend_code,
    input  wire logic                                  cfg_write_en,
    input  wire logic [swtt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [swtt_pkg::CT_W-1:0]             cfg_data
);
    import swtt_pkg::*;

    state_t state_reg, state_next;

    logic [LEN_W-1:0]  window_length_reg, window_length_next;
    logic [CT_W-1:0]   critical_t_reg, critical_t_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0] oldest_reg, oldest_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]  issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] px_reg, px_next;
    logic [11:0]        sx_reg, sx_next;
    logic [17:0]        sxx_reg, sxx_next;
    logic signed [31:0] sy_reg, sy_next;
    logic signed [39:0] sxy_reg, sxy_next;
    logic [55:0]        syy_reg, syy_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic signed [63:0] a_reg, a_next;
    logic [63:0]        b_reg, b_next;
    logic [63:0]        c_reg, c_next;
    logic [MUL_W-1:0]   a2_reg, a2_next;
    logic [MUL_W-1:0]   d_reg, d_next;
    logic [MUL_W-1:0]   lhs_reg, lhs_next;
    logic [1:0]         code_reg, code_next;
    logic [1:0]         trend_reg, trend_next;

    logic [LEN_W-1:0]       n_eff;
    logic                   in_acc;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [LEN_W:0]         fill_pos;
    logic signed [SAMPLE_BITS-1:0] v;
    logic signed [30:0]     xv;
    logic signed [47:0]     vv;
    logic [11:0]            xx;
    logic [39:0]            sxy_mag;
    logic [31:0]            sy_mag;
    logic [63:0]            a_mag;
    logic [63:0]            p64;
    mul_req_t               mreq;
    logic                   mdone;
    logic [MUL_W-1:0]       mprod;

    // window length clamped to the supported range
    always_comb
    begin
        if (window_length_reg < LEN_W'(3))
        begin
            n_eff = LEN_W'(3);
        end
        else if (window_length_reg > LEN_W'(MAX_WINDOW))
        begin
            n_eff = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            n_eff = window_length_reg;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_acc     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign trend_code = trend_reg;

    // write slot for a new sample
    assign fill_pos = {2'b00, oldest_reg} + {1'b0, fill_reg};
    always_comb
    begin
        if (fill_reg < n_eff)
        begin
            if (fill_pos >= {1'b0, n_eff})
            begin
                ram_waddr = ADDR_W'(fill_pos - {1'b0, n_eff});
            end
            else
            begin
                ram_waddr = fill_pos[ADDR_W-1:0];
            end
        end
        else
        begin
            ram_waddr = oldest_reg;
        end
    end
    assign ram_we = in_acc && (command == CMD_PUSH);

    swtt_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_WINDOW)
    ) u_window (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(sample_value),
        .rd_addr(addr_reg),
        .rd_data(ram_rdata)
    );

    swtt_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mreq),
        .done   (mdone),
        .product(mprod)
    );

    // per-sample terms of the window sums
    assign v   = $signed(ram_rdata);
    assign xv  = $signed({1'b0, px_reg}) * v;
    assign vv  = v * v;
    assign xx  = px_reg * px_reg;

    // magnitudes for the unsigned multiplier
    assign sxy_mag = sxy_reg[39] ? 40'(-sxy_reg) : 40'(sxy_reg);
    assign sy_mag  = sy_reg[31]  ? 32'(-sy_reg)  : 32'(sy_reg);
    assign a_mag   = a_reg[63]   ? 64'(-a_reg)   : 64'(a_reg);
    assign p64     = mprod[63:0];

    // multiplier operands for each step
    always_comb
    begin
        mreq.start = (state_reg == ST_MGO);
        case (step_reg)
            STEP_NSXY:
            begin
                mreq.mcand = MUL_W'(sxy_mag);
                mreq.mplr  = MPLR_W'(n_eff);
            end
            STEP_SXSY:
            begin
                mreq.mcand = MUL_W'(sx_reg);
                mreq.mplr  = MPLR_W'(sy_mag);
            end
            STEP_NSXX:
            begin
                mreq.mcand = MUL_W'(sxx_reg);
                mreq.mplr  = MPLR_W'(n_eff);
            end
            STEP_SXSX:
            begin
                mreq.mcand = MUL_W'(sx_reg);
                mreq.mplr  = MPLR_W'(sx_reg);
            end
            STEP_NSYY:
            begin
                mreq.mcand = MUL_W'(syy_reg);
                mreq.mplr  = MPLR_W'(n_eff);
            end
            STEP_SYSY:
            begin
                mreq.mcand = MUL_W'(sy_mag);
                mreq.mplr  = MPLR_W'(sy_mag);
            end
            STEP_AA:
            begin
                mreq.mcand = MUL_W'(a_mag);
                mreq.mplr  = a_mag[MPLR_W-1:0];
            end
            STEP_BC:
            begin
                mreq.mcand = MUL_W'(c_reg);
                mreq.mplr  = b_reg[MPLR_W-1:0];
            end
            STEP_LHS:
            begin
                mreq.mcand = a2_reg;
                mreq.mplr  = MPLR_W'(n_eff - LEN_W'(2));
            end
            STEP_CTCT:
            begin
                mreq.mcand = MUL_W'(critical_t_reg);
                mreq.mplr  = MPLR_W'(critical_t_reg);
            end
            STEP_RHS:
            begin
                mreq.mcand = d_reg;
                mreq.mplr  = MPLR_W'(c_reg[31:0]);
            end
            default:
            begin
                mreq.mcand = '0;
                mreq.mplr  = '0;
            end
        endcase
    end

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next         = state_reg;
        window_length_next = window_length_reg;
        critical_t_next    = critical_t_reg;
        fill_next          = fill_reg;
        oldest_next        = oldest_reg;
        addr_next          = addr_reg;
        issue_next         = issue_reg;
        pend_next          = 1'b0;
        px_next            = px_reg;
        sx_next            = sx_reg;
        sxx_next           = sxx_reg;
        sy_next            = sy_reg;
        sxy_next           = sxy_reg;
        syy_next           = syy_reg;
        step_next          = step_reg;
        a_next             = a_reg;
        b_next             = b_reg;
        c_next             = c_reg;
        a2_next            = a2_reg;
        d_next             = d_reg;
        lhs_next           = lhs_reg;
        code_next          = code_reg;
        trend_next         = trend_reg;
        out_valid_next     = out_valid_reg && !out_ready;

        // register writes
        if (cfg_write_en)
        begin
            if (cfg_index == CFG_WINDOW_LENGTH)
            begin
                window_length_next = cfg_data[LEN_W-1:0];
                fill_next          = '0;
                oldest_next        = '0;
            end
            else if (cfg_index == CFG_CRITICAL_T)
            begin
                critical_t_next = cfg_data;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    sx_next  = '0;
                    sxx_next = '0;
                    sy_next  = '0;
                    sxy_next = '0;
                    syy_next = '0;
                    issue_next = '0;
                    if (command == CMD_CLEAR)
                    begin
                        fill_next   = '0;
                        oldest_next = '0;
                    end
                    else if (fill_reg < n_eff)
                    begin
                        fill_next = fill_reg + LEN_W'(1);
                        addr_next = oldest_reg;
                        if (fill_reg + LEN_W'(1) < n_eff)
                        begin
                            code_next  = TREND_UNKNOWN;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    else
                    begin
                        if ({1'b0, oldest_reg} + LEN_W'(1) == n_eff)
                        begin
                            oldest_next = '0;
                        end
                        else
                        begin
                            oldest_next = oldest_reg + ADDR_W'(1);
                        end
                        addr_next  = oldest_next;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                // accumulate the sample read last cycle
                if (pend_reg)
                begin
                    sx_next  = sx_reg + 12'(px_reg);
                    sxx_next = sxx_reg + 18'(xx);
                    sy_next  = sy_reg + 32'(v);
                    sxy_next = sxy_reg + 40'(xv);
                    syy_next = syy_reg + 56'(unsigned'(vv));
                end
                if (issue_reg < n_eff)
                begin
                    pend_next  = 1'b1;
                    px_next    = issue_reg[ADDR_W-1:0];
                    issue_next = issue_reg + LEN_W'(1);
                    if ({1'b0, addr_reg} + LEN_W'(1) == n_eff)
                    begin
                        addr_next = '0;
                    end
                    else
                    begin
                        addr_next = addr_reg + ADDR_W'(1);
                    end
                end
                else if (!pend_reg)
                begin
                    step_next  = STEP_NSXY;
                    state_next = ST_MGO;
                end
            end
            ST_MGO:
            begin
                state_next = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (mdone)
                begin
                    step_next  = step_reg + STEP_W'(1);
                    state_next = ST_MGO;
                    case (step_reg)
                        STEP_NSXY: a_next = sxy_reg[39] ? -$signed(p64) : $signed(p64);
                        STEP_SXSY: a_next = sy_reg[31] ? a_reg + $signed(p64)
                                                       : a_reg - $signed(p64);
                        STEP_NSXX: b_next = p64;
                        STEP_SXSX: b_next = b_reg - p64;
                        STEP_NSYY: c_next = p64;
                        STEP_SYSY: c_next = c_reg - p64;
                        STEP_AA:   a2_next = mprod;
                        STEP_BC:   d_next = mprod - a2_reg;
                        STEP_LHS:  lhs_next = {mprod[MUL_W-25:0], 24'b0};
                        STEP_CTCT: c_next = p64;
                        STEP_RHS:
                        begin
                            if (lhs_reg > mprod)
                            begin
                                code_next = a_reg[63] ? TREND_FALLING : TREND_RISING;
                            end
                            else
                            begin
                                code_next = TREND_STEADY;
                            end
                            state_next = ST_DONE;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_DONE:
            begin
                // hand the result over once the output slot is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    trend_next     = code_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= LEN_W'(6);
            critical_t_reg    <= CT_W'(11372);
            fill_reg          <= '0;
            oldest_reg        <= '0;
            pend_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            window_length_reg <= window_length_next;
            critical_t_reg    <= critical_t_next;
            fill_reg          <= fill_next;
            oldest_reg        <= oldest_next;
            pend_reg          <= pend_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        issue_reg <= issue_next;
        px_reg    <= px_next;
        sx_reg    <= sx_next;
        sxx_reg   <= sxx_next;
        sy_reg    <= sy_next;
        sxy_reg   <= sxy_next;
        syy_reg   <= syy_next;
        step_reg  <= step_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        a2_reg    <= a2_next;
        d_reg     <= d_next;
        lhs_reg   <= lhs_next;
        code_reg  <= code_next;
        trend_reg <= trend_next;
    end

endmodule
`default_nettype wire

// ===== rtl/swtt_checker.sv =====
// port-level checks for the trend test block and their bind
`default_nettype none
module swtt_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       command,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] trend_code,
    input wire logic       cfg_write_en
);
    import swtt_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(trend_code))
        else $error("stalled result changed");

    // a push request leaves the block busy right after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_PUSH |=> !in_ready)
        else $error("ready right after a push");

    // a clear request leaves the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_CLEAR |=> in_ready)
        else $error("not ready after a clear");

    // a new result only appears after the block was busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without work");

    // register writes must land only while the block is idle; the block itself does not enforce it
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_en |-> in_ready)
        else $error("register write while busy");

endmodule

bind sliding_window_trend_test_top swtt_checker u_swtt_checker (.*);
`default_nettype wire

// ===== tb/sliding_window_trend_test_top_test.sv =====
// self-checking testbench for the sliding window trend test block
`timescale 1ns / 1ps
`default_nettype none

// trend predictor and expected-trend store
class trend_scoreboard;
    longint       window_mem [swtt_pkg::MAX_WINDOW];
    int unsigned  fill;
    int unsigned  oldest;
    int unsigned  win_len;
    int unsigned  crit_t;
    logic [1:0]   pending_trends [$];
    int unsigned  fail_count;

    function new();
        win_len = 6;
        crit_t = 11372;
        fill = 0;
        oldest = 0;
        fail_count = 0;
        foreach (window_mem[i]) window_mem[i] = 0;
    endfunction

    // mirror a register write
    function void note_config(logic [1:0] idx, logic [15:0] data);
        if (idx == swtt_pkg::CFG_WINDOW_LENGTH)
        begin
            win_len = data[6:0];
            fill = 0;
            oldest = 0;
        end
        else if (idx == swtt_pkg::CFG_CRITICAL_T)
        begin
            crit_t = data;
        end
    endfunction

    // predict the trend caused by an accepted request
    function void note_request(logic cmd, logic signed [23:0] sample);
        int unsigned n;
        longint y, sx, sxx, sy, sxy, a, b, v;
        bit [255:0] syy, c, a2, d, lhs, rhs, t, bw;
        n = (win_len < 3) ? 3
          : ((win_len > swtt_pkg::MAX_WINDOW) ? swtt_pkg::MAX_WINDOW : win_len);
        if (cmd == swtt_pkg::CMD_CLEAR)
        begin
            fill = 0;
            oldest = 0;
            return;
        end
        y = sample;
        if (oldest >= n) oldest = 0;
        if (fill < n)
        begin
            window_mem[(oldest + fill) % n] = y;
            fill++;
            if (fill < n)
            begin
                pending_trends.push_back(swtt_pkg::TREND_UNKNOWN);
                return;
            end
        end
        else
        begin
            window_mem[oldest] = y;
            oldest = (oldest + 1) % n;
        end
        // window sums with x counted from the oldest sample
        sx = 0; sxx = 0; sy = 0; sxy = 0; syy = '0;
        for (int k = 0; k < n; k++)
        begin
            v = window_mem[(oldest + k) % n];
            sx += k;
            sxx += k * k;
            sy += v;
            sxy += k * v;
            t = (v < 0) ? -v : v;
            syy += t * t;
        end
        a = n * sxy - sx * sy;
        b = n * sxx - sx * sx;
        t = (sy < 0) ? -sy : sy;
        c = syy * n - t * t;
        t = (a < 0) ? -a : a;
        a2 = t * t;
        bw = b;
        d = bw * c - a2;
        t = (n - 2) << 24;
        lhs = a2 * t;
        t = crit_t * crit_t;
        rhs = t * d;
        if (lhs > rhs)
            pending_trends.push_back(a < 0 ? swtt_pkg::TREND_FALLING : swtt_pkg::TREND_RISING);
        else
            pending_trends.push_back(swtt_pkg::TREND_STEADY);
    endfunction

    // compare a returned trend with the oldest prediction
    function void check_result(logic [1:0] code);
        logic [1:0] want;
        if (pending_trends.size() == 0)
        begin
            $error("trend_code: unexpected result %0d", code);
            fail_count++;
            return;
        end
        want = pending_trends.pop_front();
        if (code !== want)
        begin
            $error("trend_code: expected %0d, actual %0d", want, code);
            fail_count++;
        end
    endfunction
endclass

module sliding_window_trend_test_top_test;
    import swtt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;
    localparam int SETTLE_CYCLES = 400;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic                          command;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          out_valid;
    logic                          out_ready;
    logic [1:0]                    trend_code;
    logic                          cfg_write_en;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CT_W-1:0]               cfg_data;

    trend_scoreboard sb;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;

    sliding_window_trend_test_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .trend_code   (trend_code),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(trend_code);
    end

    // send one request, called at a falling edge, returns at a falling edge
    task automatic send_request(input logic cmd, input logic signed [23:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        sample_value <= val;
        do @(posedge clk); while (!in_ready);
        sb.note_request(cmd, val);
        @(negedge clk);
    endtask

    // wait for every expected trend, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_trends.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CT_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        sb.note_config(idx, data);
        @(negedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    // clamp to the signed sample range
    function automatic logic signed [23:0] clip24(input longint v);
        if (v > 8388607) return 24'sd8388607;
        if (v < -8388608) return -24'sd8388608;
        return v[23:0];
    endfunction

    // random burst: mostly noisy lines, some raw noise and clears
    task automatic random_burst(input int count);
        longint base, slope, noise, v;
        int kind;
        base = 0; slope = 0; noise = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 16 == 0)
            begin
                base  = $signed($urandom_range(16777215)) - 8388608;
                slope = $signed($urandom_range(2000)) - 1000;
                if ($urandom_range(3) == 0) slope = slope * 4000;
                noise = 1 << $urandom_range(20);
                if ($urandom_range(4) == 0) noise = 0;
            end
            kind = $urandom_range(99);
            if (kind < 5)
                send_request(CMD_CLEAR, 24'($urandom));
            else if (kind < 20)
                send_request(CMD_PUSH, 24'($urandom));
            else
            begin
                v = base + slope * (i % 16);
                if (noise != 0) v += $signed($urandom_range(2 * noise)) - noise;
                send_request(CMD_PUSH, clip24(v));
            end
        end
    endtask

    int unsigned lengths [8] = '{3, 64, 0, 127, 4, 10, 5, 20};
    int unsigned crits   [8] = '{0, 65535, 4096, 11372, 20000, 8000, 1, 30000};
    int unsigned counts  [8] = '{50, 30, 50, 20, 50, 50, 50, 50};

    // main sequence
    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_PUSH;
        sample_value = '0;
        out_ready = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = CFG_WINDOW_LENGTH;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // directed: default window of six
        for (int k = 0; k < 6; k++) send_request(CMD_PUSH, 24'(k * 1000));   // exact line
        send_request(CMD_PUSH, 24'sd8388607);
        send_request(CMD_PUSH, -24'sd8388608);
        for (int k = 0; k < 6; k++) send_request(CMD_PUSH, 24'sd5);        // flat
        send_request(CMD_CLEAR, 24'sd0);
        for (int k = 0; k < 6; k++) send_request(CMD_PUSH, clip24(8388607 - k * 3355443));
        send_request(CMD_PUSH, -24'sd8388608);
        drain();
        write_reg(CFG_UNUSED, 16'hFFFF);

        // phases of settings and idling
        for (int p = 0; p < 8; p++)
        begin
            write_reg(CFG_WINDOW_LENGTH, 16'(lengths[p]));
            write_reg(CFG_CRITICAL_T, 16'(crits[p]));
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 59;
                    recv_idle_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 59;
                end
                default:
                begin
                    send_idle_pct = 35;
                    recv_idle_pct = 35;
                end
            endcase
            random_burst(counts[p] / 2);
            // hold off until every expected trend is back
            in_valid <= 1'b0;
            while (sb.pending_trends.size() != 0) @(negedge clk);
            random_burst(counts[p] - counts[p] / 2);
            drain();
        end

        if (sb.fail_count == 0)
            $display("sliding_window_trend_test_top: match");
        else
            $display("sliding_window_trend_test_top: mismatch");
        $finish;
    end

    // timeout
    initial
    begin
        #100ms;
        $display("sliding_window_trend_test_top: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
